FILE: rtl/gmd_pkg.sv
// ----------------------------------------------------------------------------
// gmd_pkg
// Shared types and constants for the grid maze depth-first solver.
// ----------------------------------------------------------------------------
package gmd_pkg;

    localparam int GRID_ROWS_DEF = 8;
    localparam int GRID_COLS_DEF = 8;
    localparam int CELLS         = 64;
    localparam int CELL_AW       = 6;
    localparam int STACK_W       = 8;
    localparam int DEPTH_W       = 7;

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic       OP_SOLVE = 1'b1;

    localparam logic [2:0] KIND_OPEN  = 3'd0;
    localparam logic [2:0] KIND_WALL  = 3'd1;
    localparam logic [2:0] KIND_START = 3'd2;
    localparam logic [2:0] KIND_GOAL  = 3'd3;
    localparam logic [2:0] KIND_PATH  = 3'd4;

    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_PATH = 2'd1;
    localparam logic [1:0] MARK_DEAD = 2'd2;

    localparam logic [1:0] DIR_EAST  = 2'd0;
    localparam logic [1:0] DIR_WEST  = 2'd1;
    localparam logic [1:0] DIR_SOUTH = 2'd2;
    localparam logic [1:0] DIR_NORTH = 2'd3;
    localparam logic [2:0] DIR_DONE  = 3'd4;

    localparam logic [2:0] ADDR_ROWS = 3'd0;
    localparam logic [2:0] ADDR_COLS = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_INIT,
        S_TOP_RD,
        S_TOP_WT,
        S_NB,
        S_NB_WT,
        S_PUSH,
        S_EM_RD,
        S_EM_LD,
        S_NF
    } t_state;

    // neighbor unit result
    typedef struct packed {
        logic                ok;
        logic [CELL_AW-1:0]  addr;
    } t_nbr;

endpackage

FILE: rtl/gmd_ram.sv
// ----------------------------------------------------------------------------
// gmd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/gmd_nbr.sv
// ----------------------------------------------------------------------------
// gmd_nbr
// Shared neighbor unit: next cell address in one direction, with bounds check.
// ----------------------------------------------------------------------------
module gmd_nbr (
    input  logic [gmd_pkg::CELL_AW-1:0] i_cell,
    input  logic [1:0]                  i_dir,
    input  logic [3:0]                  i_rows,
    input  logic [3:0]                  i_cols,
    output gmd_pkg::t_nbr               o_nbr
);

    logic [2:0] w_r;
    logic [2:0] w_c;
    logic [3:0] w_r1;
    logic [3:0] w_c1;

    assign w_r  = i_cell[5:3];
    assign w_c  = i_cell[2:0];
    assign w_r1 = {1'b0, w_r} + 4'd1;
    assign w_c1 = {1'b0, w_c} + 4'd1;

    always_comb begin
        o_nbr = '0;
        case (i_dir)
            gmd_pkg::DIR_EAST: begin
                o_nbr.ok   = (w_c1 < i_cols);
                o_nbr.addr = {w_r, w_c1[2:0]};
            end
            gmd_pkg::DIR_WEST: begin
                o_nbr.ok   = (w_c != 3'd0);
                o_nbr.addr = {w_r, w_c - 3'd1};
            end
            gmd_pkg::DIR_SOUTH: begin
                o_nbr.ok   = (w_r1 < i_rows);
                o_nbr.addr = {w_r1[2:0], w_c};
            end
            default: begin
                o_nbr.ok   = (w_r != 3'd0);
                o_nbr.addr = {w_r - 3'd1, w_c};
            end
        endcase
    end

endmodule

FILE: rtl/grid_maze_dfs_solver.sv
// ----------------------------------------------------------------------------
// grid_maze_dfs_solver
// Loads an 8x8 maze cell by cell and solves it by depth-first search.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    op, cell_row, cell_col, cell_kind
//   output    out        o_out_valid / i_out_stall  found, out_row, out_col, out_kind, last
//   config    in         APB psel/penable/pwrite    rows_in_use @0, cols_in_use @4
//
// load transaction: the cell is written as it is accepted, and the input stays open for the next item
// solve: scans for the start while clearing the mark store, then tries
//   neighbors one at a time and steps back on dead ends, paced by the single
//   neighbor unit and the one read port of each store; emit reads then loads each cell
// reset clears control state and the per-cell valid bits of the maze store
// a stalled output holds the emit and the not-found result; input stays stalled until the run ends
// ----------------------------------------------------------------------------
module grid_maze_dfs_solver #(
    parameter int GRID_ROWS = gmd_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = gmd_pkg::GRID_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [2:0]  i_cell_row,
    input  logic [2:0]  i_cell_col,
    input  logic [1:0]  i_cell_kind,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_found,
    output logic [2:0]  o_out_row,
    output logic [2:0]  o_out_col,
    output logic [2:0]  o_out_kind,
    output logic        o_last
);

    localparam int AW = gmd_pkg::CELL_AW;

    gmd_pkg::t_state r_state, n_state;

    logic [3:0]            r_rows_raw, r_cols_raw;
    logic [3:0]            w_rows, w_cols;
    logic [gmd_pkg::CELLS-1:0] r_gvalid;
    logic                  r_gv_rd;
    logic [6:0]            r_addr, n_addr;
    logic                  r_scan_v, n_scan_v;
    logic [AW-1:0]         r_scan_a, n_scan_a;
    logic [AW-1:0]         r_start, n_start;
    logic                  r_have, n_have;
    logic [gmd_pkg::DEPTH_W-1:0] r_depth, n_depth;
    logic                  r_ret, n_ret;
    logic [AW-1:0]         r_cell, n_cell;
    logic [2:0]            r_k, n_k;
    logic [AW-1:0]         r_nbr, n_nbr;

    logic                  r_out_valid;
    logic                  r_found, r_last;
    logic [2:0]            r_orow, r_ocol, r_okind;

    // memory controls
    logic                  g_we, g_re;
    logic [AW-1:0]         g_waddr, g_raddr;
    logic [1:0]            g_wdata, g_rdata;
    logic                  m_we, m_re;
    logic [AW-1:0]         m_waddr, m_raddr;
    logic [1:0]            m_wdata, m_rdata;
    logic                  s_we, s_re;
    logic [AW-1:0]         s_waddr, s_raddr;
    logic [gmd_pkg::STACK_W-1:0] s_wdata, s_rdata;

    gmd_pkg::t_nbr         w_nbr;
    logic                  w_in_acc, w_out_free, w_load_out;
    logic                  n_found, n_last;
    logic [2:0]            n_orow, n_ocol, n_okind;
    logic [2:0]            w_gkind;
    logic                  w_start_hit, w_enter, w_em_last;
    logic                  w_cfg_wr;

    // ---------------- configuration ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_raw <= 4'd8;
            r_cols_raw <= 4'd8;
        end else if (w_cfg_wr) begin
            if (paddr == gmd_pkg::ADDR_ROWS) r_rows_raw <= pwdata[3:0];
            if (paddr == gmd_pkg::ADDR_COLS) r_cols_raw <= pwdata[3:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == gmd_pkg::ADDR_ROWS) prdata = {28'd0, r_rows_raw};
        if (paddr == gmd_pkg::ADDR_COLS) prdata = {28'd0, r_cols_raw};
    end

    assign w_rows = (r_rows_raw == 4'd0) ? 4'd1 :
                    (r_rows_raw > 4'(GRID_ROWS)) ? 4'(GRID_ROWS) : r_rows_raw;
    assign w_cols = (r_cols_raw == 4'd0) ? 4'd1 :
                    (r_cols_raw > 4'(GRID_COLS)) ? 4'(GRID_COLS) : r_cols_raw;

    // ---------------- stores ----------------
    gmd_ram #(.WIDTH(2), .DEPTH(gmd_pkg::CELLS)) u_grid (
        .i_clk, .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_re(g_re), .i_raddr(g_raddr), .o_rdata(g_rdata)
    );

    gmd_ram #(.WIDTH(2), .DEPTH(gmd_pkg::CELLS)) u_mark (
        .i_clk, .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_re(m_re), .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    gmd_ram #(.WIDTH(gmd_pkg::STACK_W), .DEPTH(gmd_pkg::CELLS)) u_stack (
        .i_clk, .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_re(s_re), .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gvalid <= '0;
        end else if (g_we) begin
            r_gvalid[g_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_re) r_gv_rd <= r_gvalid[g_raddr];
    end

    // never-loaded cells read as open
    assign w_gkind = r_gv_rd ? {1'b0, g_rdata} : gmd_pkg::KIND_OPEN;

    gmd_nbr u_nbr (
        .i_cell(r_cell), .i_dir(r_k[1:0]), .i_rows(w_rows), .i_cols(w_cols),
        .o_nbr(w_nbr)
    );

    // ---------------- shared decode ----------------
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_start_hit = r_scan_v && (w_gkind == gmd_pkg::KIND_START) &&
                         ({1'b0, r_scan_a[5:3]} < w_rows) &&
                         ({1'b0, r_scan_a[2:0]} < w_cols);
    assign w_enter = (m_rdata == gmd_pkg::MARK_NONE) &&
                     ((w_gkind == gmd_pkg::KIND_OPEN) || (w_gkind == gmd_pkg::KIND_GOAL));
    assign w_em_last = ({1'b0, r_addr[5:3]} == w_rows - 4'd1) &&
                       ({1'b0, r_addr[2:0]} == w_cols - 4'd1);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gmd_pkg::S_IDLE:
                if (w_in_acc && i_op == gmd_pkg::OP_SOLVE) n_state = gmd_pkg::S_SCAN;
            gmd_pkg::S_SCAN:
                if (r_addr == 7'd63) n_state = gmd_pkg::S_SCAN_END;
            gmd_pkg::S_SCAN_END:
                n_state = (r_have || w_start_hit) ? gmd_pkg::S_INIT : gmd_pkg::S_NF;
            gmd_pkg::S_INIT:   n_state = gmd_pkg::S_TOP_RD;
            gmd_pkg::S_TOP_RD: n_state = gmd_pkg::S_TOP_WT;
            gmd_pkg::S_TOP_WT: n_state = gmd_pkg::S_NB;
            gmd_pkg::S_NB:
                if (r_k == gmd_pkg::DIR_DONE) begin
                    n_state = (r_depth == 7'd1) ? gmd_pkg::S_NF : gmd_pkg::S_TOP_RD;
                end else if (w_nbr.ok) begin
                    n_state = gmd_pkg::S_NB_WT;
                end
            gmd_pkg::S_NB_WT:
                if (w_enter && w_gkind == gmd_pkg::KIND_GOAL) n_state = gmd_pkg::S_EM_RD;
                else if (w_enter) n_state = gmd_pkg::S_PUSH;
                else n_state = gmd_pkg::S_NB;
            gmd_pkg::S_PUSH:  n_state = gmd_pkg::S_NB;
            gmd_pkg::S_EM_RD: n_state = gmd_pkg::S_EM_LD;
            gmd_pkg::S_EM_LD:
                if (w_out_free) n_state = w_em_last ? gmd_pkg::S_IDLE : gmd_pkg::S_EM_RD;
            gmd_pkg::S_NF:
                if (w_out_free) n_state = gmd_pkg::S_IDLE;
            default: n_state = gmd_pkg::S_IDLE;
        endcase
    end

    // ---------------- outputs and datapath ----------------
    always_comb begin
        o_in_stall = (r_state != gmd_pkg::S_IDLE);
        g_we = 1'b0; g_waddr = {i_cell_row, i_cell_col}; g_wdata = i_cell_kind;
        g_re = 1'b0; g_raddr = r_addr[5:0];
        m_we = 1'b0; m_waddr = r_addr[5:0]; m_wdata = gmd_pkg::MARK_NONE;
        m_re = 1'b0; m_raddr = r_addr[5:0];
        s_we = 1'b0; s_waddr = '0; s_wdata = '0;
        s_re = 1'b0; s_raddr = r_depth[5:0] - 6'd1;
        n_addr = r_addr; n_scan_v = r_scan_v; n_scan_a = r_scan_a;
        n_start = r_start; n_have = r_have; n_depth = r_depth; n_ret = r_ret;
        n_cell = r_cell; n_k = r_k; n_nbr = r_nbr;
        w_load_out = 1'b0;
        n_found = 1'b0; n_orow = 3'd0; n_ocol = 3'd0;
        n_okind = gmd_pkg::KIND_OPEN; n_last = 1'b1;

        unique case (r_state)
            gmd_pkg::S_IDLE: begin
                if (w_in_acc && i_op == gmd_pkg::OP_LOAD &&
                    {1'b0, i_cell_row} < 4'(GRID_ROWS) &&
                    {1'b0, i_cell_col} < 4'(GRID_COLS)) begin
                    g_we = 1'b1;
                end
                n_addr = '0; n_scan_v = 1'b0; n_have = 1'b0;
            end
            gmd_pkg::S_SCAN: begin
                g_re = 1'b1;
                m_we = 1'b1;
                n_scan_v = 1'b1;
                n_scan_a = r_addr[5:0];
                n_addr = r_addr + 7'd1;
                if (w_start_hit) begin
                    n_start = r_scan_a; n_have = 1'b1;
                end
            end
            gmd_pkg::S_SCAN_END: begin
                n_scan_v = 1'b0;
                if (w_start_hit) begin
                    n_start = r_scan_a; n_have = 1'b1;
                end
            end
            gmd_pkg::S_INIT: begin
                s_we = 1'b1; s_waddr = '0; s_wdata = {2'b00, r_start};
                m_we = 1'b1; m_waddr = r_start; m_wdata = gmd_pkg::MARK_PATH;
                n_depth = 7'd1; n_ret = 1'b0;
            end
            gmd_pkg::S_TOP_RD: s_re = 1'b1;
            gmd_pkg::S_TOP_WT: begin
                n_cell = s_rdata[5:0];
                n_k = r_ret ? ({1'b0, s_rdata[7:6]} + 3'd1) : 3'd0;
            end
            gmd_pkg::S_NB: begin
                if (r_k == gmd_pkg::DIR_DONE) begin
                    // dead end, keep it closed for the rest of this search
                    m_we = 1'b1; m_waddr = r_cell; m_wdata = gmd_pkg::MARK_DEAD;
                    n_depth = r_depth - 7'd1; n_ret = 1'b1;
                end else if (w_nbr.ok) begin
                    g_re = 1'b1; g_raddr = w_nbr.addr;
                    m_re = 1'b1; m_raddr = w_nbr.addr;
                    n_nbr = w_nbr.addr;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            gmd_pkg::S_NB_WT: begin
                n_addr = '0;
                if (w_enter && w_gkind != gmd_pkg::KIND_GOAL) begin
                    s_we = 1'b1; s_waddr = r_depth[5:0] - 6'd1;
                    s_wdata = {r_k[1:0], r_cell};
                end else if (!w_enter) begin
                    n_k = r_k + 3'd1;
                end
            end
            gmd_pkg::S_PUSH: begin
                n_ret = 1'b0; n_k = 3'd0;
                if (r_depth < 7'd64) begin
                    s_we = 1'b1; s_waddr = r_depth[5:0]; s_wdata = {2'b00, r_nbr};
                    m_we = 1'b1; m_waddr = r_nbr; m_wdata = gmd_pkg::MARK_PATH;
                    n_depth = r_depth + 7'd1;
                    n_cell = r_nbr;
                end
            end
            gmd_pkg::S_EM_RD: begin
                g_re = 1'b1;
                m_re = 1'b1;
            end
            gmd_pkg::S_EM_LD: begin
                w_load_out = w_out_free;
                n_found = 1'b1;
                n_orow = r_addr[5:3];
                n_ocol = r_addr[2:0];
                n_last = w_em_last;
                if (m_rdata == gmd_pkg::MARK_PATH) begin
                    n_okind = (r_addr[5:0] == r_start) ? gmd_pkg::KIND_START
                                                       : gmd_pkg::KIND_PATH;
                end else begin
                    n_okind = w_gkind;
                end
                if (w_out_free) begin
                    if ({1'b0, r_addr[2:0]} == w_cols - 4'd1) begin
                        n_addr = {1'b0, r_addr[5:3] + 3'd1, 3'd0};
                    end else begin
                        n_addr = r_addr + 7'd1;
                    end
                end
            end
            gmd_pkg::S_NF: begin
                w_load_out = w_out_free;
                n_depth = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gmd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_depth     <= '0;
            r_scan_v    <= 1'b0;
            r_have      <= 1'b0;
            r_ret       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_depth  <= n_depth;
            r_scan_v <= n_scan_v;
            r_have   <= n_have;
            r_ret    <= n_ret;
            if (w_load_out) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_scan_a <= n_scan_a;
        r_start  <= n_start;
        r_cell   <= n_cell;
        r_k      <= n_k;
        r_nbr    <= n_nbr;
        if (w_load_out) begin
            r_found <= n_found;
            r_orow  <= n_orow;
            r_ocol  <= n_ocol;
            r_okind <= n_okind;
            r_last  <= n_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_out_row   = r_orow;
    assign o_out_col   = r_ocol;
    assign o_out_kind  = r_okind;
    assign o_last      = r_last;

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= 7'd64)
        else $error("path depth beyond store size");

    a_nf_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmd_pkg::S_NF) && w_out_free |=> o_out_valid && o_last && !o_found)
        else $error("not-found result malformed");

    a_nf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_last)
        else $error("not-found transaction without last");

    a_search_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmd_pkg::S_NB) || (r_state == gmd_pkg::S_NB_WT) |-> r_depth != 7'd0)
        else $error("search running with empty path");
`endif

endmodule
